>>> design/spanning_tree_root_election_table_top_assert.svh
// ----------------------------------------------------------------------------
// Root election table assertion macros
// Shared forms for the concurrent checks of the root election table.
// ----------------------------------------------------------------------------
`ifndef SPANNING_TREE_ROOT_ELECTION_TABLE_TOP_ASSERT_SVH
`define SPANNING_TREE_ROOT_ELECTION_TABLE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STRT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/strt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Root election table package
// Field widths, the empty markers and the stored entry layout.
// ----------------------------------------------------------------------------
package strt_pkg;

   localparam int ID_W     = 7;
   localparam int LAN_W    = 8;
   localparam int DIST_W   = 8;
   localparam int SEND_W   = 8;
   localparam int MAX_IDS  = 128;

   localparam logic [DIST_W-1:0] DIST_NONE   = 8'hFF;
   localparam logic [SEND_W-1:0] SENDER_NONE = 8'hFF;

   typedef struct packed {
      logic [ID_W-1:0]   root;
      logic [DIST_W-1:0] distance;
      logic [SEND_W-1:0] sender;
      logic [LAN_W-1:0]  lan;
   } entry_type;

   typedef struct packed {
      logic      en;
      entry_type data;
   } wr_req_type;

endpackage

>>> design/strt_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Root election entry table
// One entry per bridge with a registered read, per-entry valid bits and a
// bypass of the write that lands on the same edge as the read.
// ----------------------------------------------------------------------------
module strt_table
   import strt_pkg::*;
#(
   parameter int DEPTH  = 128,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [ADDR_W-1:0] rd_addr,
   input  logic [ADDR_W-1:0] wr_addr,
   input  wr_req_type        wr_req,
   output entry_type         cur_entry
);

   entry_type         mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   entry_type         rd_data_ff;
   logic [ADDR_W-1:0] rd_addr_ff;
   logic              fwd_hit_ff;
   entry_type         fwd_data_ff;
   entry_type         reset_entry;

   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem[wr_addr] <= wr_req.data;
      end
      rd_data_ff  <= mem[rd_addr];
      rd_addr_ff  <= rd_addr;
      fwd_data_ff <= wr_req.data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         fwd_hit_ff <= 1'b0;
      end else begin
         if (wr_req.en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         // The array read misses a write on the same edge; remember it.
         fwd_hit_ff <= wr_req.en && (wr_addr == rd_addr);
      end
   end

   always_comb begin
      reset_entry.root     = ID_W'(rd_addr_ff);
      reset_entry.distance = DIST_NONE;
      reset_entry.sender   = SENDER_NONE;
      reset_entry.lan      = '0;
      if (fwd_hit_ff) begin
         cur_entry = fwd_data_ff;
      end else if (valid_ff[rd_addr_ff]) begin
         cur_entry = rd_data_ff;
      end else begin
         cur_entry = reset_entry;
      end
   end

endmodule

>>> design/strt_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Root election compare
// Decides whether a message beats the stored best offer of its bridge.
// ----------------------------------------------------------------------------
module strt_decide
   import strt_pkg::*;
(
   input  entry_type         cur_entry,
   input  logic [ID_W-1:0]   msg_root,
   input  logic [DIST_W-1:0] new_distance,
   input  logic [SEND_W-1:0] msg_sender,
   output logic              take
);

   logic has_dist;
   logic has_send;
   logic same_root;

   assign has_dist  = (cur_entry.distance != DIST_NONE);
   assign has_send  = (cur_entry.sender != SENDER_NONE);
   assign same_root = (msg_root == cur_entry.root);

   always_comb begin
      take = 1'b0;
      if (msg_root < cur_entry.root) begin
         take = 1'b1;
      end else if (same_root && has_dist) begin
         if (new_distance < cur_entry.distance) begin
            take = 1'b1;
         end else if ((new_distance == cur_entry.distance) && has_send &&
                      (msg_sender < cur_entry.sender)) begin
            take = 1'b1;
         end
      end
   end

endmodule

>>> design/spanning_tree_root_election_table_top.sv
`timescale 1ns / 1ps
// Pipeline: the transaction is captured into the s1 registers while the table is
// read; s1 decides and writes the table, and the result strobe and fields load from s1.
// Throughput: one transaction per cycle, set by the single table read and write
// port; busy stays low.
// Reset clears the per-entry valid bits, so every bridge reads as its own root
// with no distance. The receiver cannot stall results.
// ----------------------------------------------------------------------------
// Spanning tree root election table
// Keeps the best root offer per bridge and reports each message's outcome.
// ----------------------------------------------------------------------------
`include "spanning_tree_root_election_table_top_assert.svh"

module spanning_tree_root_election_table_top
   import strt_pkg::*;
#(
   parameter int NUM_BRIDGES = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [ID_W-1:0]   req_dest_bridge,
   input  logic [ID_W-1:0]   req_msg_root,
   input  logic [ID_W-1:0]   req_msg_distance,
   input  logic [ID_W-1:0]   req_msg_sender,
   input  logic [LAN_W-1:0]  req_arrival_lan,
   output logic              rsp_valid,
   output logic              rsp_publish,
   output logic [ID_W-1:0]   rsp_adv_root,
   output logic [ID_W-1:0]   rsp_adv_distance,
   output logic [ID_W-1:0]   rsp_adv_sender
);

   // Only indices that fit the destination field can ever be addressed.
   localparam int ENTRY_COUNT = (NUM_BRIDGES < MAX_IDS) ? NUM_BRIDGES : MAX_IDS;
   localparam int ADDR_W      = $clog2(ENTRY_COUNT);

   logic              accept;
   logic              s1_valid_ff;
   logic              s1_in_range_ff;
   logic [ID_W-1:0]   s1_dest_ff;
   logic [ID_W-1:0]   s1_root_ff;
   logic [ID_W-1:0]   s1_dist_ff;
   logic [ID_W-1:0]   s1_sender_ff;
   logic [LAN_W-1:0]  s1_lan_ff;

   logic              rsp_valid_ff;
   logic              rsp_publish_ff;
   logic              rsp_publish_in;
   logic [ID_W-1:0]   rsp_adv_root_ff;
   logic [ID_W-1:0]   rsp_adv_root_in;
   logic [ID_W-1:0]   rsp_adv_distance_ff;
   logic [ID_W-1:0]   rsp_adv_distance_in;
   logic [ID_W-1:0]   rsp_adv_sender_ff;
   logic [ID_W-1:0]   rsp_adv_sender_in;

   entry_type         cur_entry;
   wr_req_type        wr_req;
   logic [DIST_W-1:0] new_distance;
   logic [SEND_W-1:0] msg_sender_ext;
   logic              better;
   logic              take;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_in_range_ff <= (8'(req_dest_bridge) < 8'(ENTRY_COUNT));
         s1_dest_ff     <= req_dest_bridge;
         s1_root_ff     <= req_msg_root;
         s1_dist_ff     <= req_msg_distance;
         s1_sender_ff   <= req_msg_sender;
         s1_lan_ff      <= req_arrival_lan;
      end
      rsp_publish_ff      <= rsp_publish_in;
      rsp_adv_root_ff     <= rsp_adv_root_in;
      rsp_adv_distance_ff <= rsp_adv_distance_in;
      rsp_adv_sender_ff   <= rsp_adv_sender_in;
   end

   strt_table #(
      .DEPTH  (ENTRY_COUNT),
      .ADDR_W (ADDR_W)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .rd_addr   (req_dest_bridge[ADDR_W-1:0]),
      .wr_addr   (s1_dest_ff[ADDR_W-1:0]),
      .wr_req    (wr_req),
      .cur_entry (cur_entry)
   );

   assign new_distance   = DIST_W'(s1_dist_ff) + DIST_W'(1);
   assign msg_sender_ext = SEND_W'(s1_sender_ff);

   strt_decide u_decide (
      .cur_entry    (cur_entry),
      .msg_root     (s1_root_ff),
      .new_distance (new_distance),
      .msg_sender   (msg_sender_ext),
      .take         (better)
   );

   assign take = s1_valid_ff && s1_in_range_ff && better;

   always_comb begin
      wr_req.en            = take;
      wr_req.data.root     = s1_root_ff;
      wr_req.data.distance = new_distance;
      wr_req.data.sender   = msg_sender_ext;
      wr_req.data.lan      = s1_lan_ff;
   end

   always_comb begin
      rsp_publish_in      = take;
      rsp_adv_root_in     = take ? s1_root_ff : '0;
      rsp_adv_distance_in = '0;
      rsp_adv_sender_in   = '0;
      if (s1_in_range_ff) begin
         rsp_adv_distance_in = new_distance[ID_W-1:0];
         rsp_adv_sender_in   = s1_dest_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_publish      = rsp_publish_ff;
   assign rsp_adv_root     = rsp_adv_root_ff;
   assign rsp_adv_distance = rsp_adv_distance_ff;
   assign rsp_adv_sender   = rsp_adv_sender_ff;

   `STRT_ASSERT_NOW(a_publish_has_strobe, clock, reset,
      rsp_publish_ff && !rsp_valid_ff, 1'b0, "publish set without a result strobe")
   `STRT_ASSERT_NOW(a_accept_gives_result, clock, reset,
      accept, ##2 rsp_valid_ff, "accepted transaction produced no result")
   `STRT_ASSERT_NEXT(a_write_publishes, clock, reset,
      wr_req.en, rsp_valid_ff && rsp_publish_ff, "table write without a published result")
   `STRT_ASSERT_NOW(a_quiet_root_zero, clock, reset,
      rsp_valid_ff && !rsp_publish_ff, rsp_adv_root_ff == '0,
      "advertised root nonzero without publish")

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Root election table testbench
// Sends configuration messages through the start/busy port, predicts each
// bridge entry's best root, distance and sender in a local table, and
// compares every result strobe with the oldest predicted advertisement.
// ----------------------------------------------------------------------------
module tb
   import strt_pkg::*;
();

   localparam int CYCLE_LIMIT  = 50000;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_IDLE  = 400;
   localparam int RANDOM_BURST = 100;
   localparam int ADV_DEPTH    = 1024;

   typedef struct packed {
      logic            publish;
      logic [ID_W-1:0] root;
      logic [ID_W-1:0] distance;
      logic [ID_W-1:0] sender;
   } adv_type;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              start            = 1'b0;
   logic [ID_W-1:0]   req_dest_bridge  = '0;
   logic [ID_W-1:0]   req_msg_root     = '0;
   logic [ID_W-1:0]   req_msg_distance = '0;
   logic [ID_W-1:0]   req_msg_sender   = '0;
   logic [LAN_W-1:0]  req_arrival_lan  = '0;
   logic              busy;
   logic              rsp_valid;
   logic              rsp_publish;
   logic [ID_W-1:0]   rsp_adv_root;
   logic [ID_W-1:0]   rsp_adv_distance;
   logic [ID_W-1:0]   rsp_adv_sender;

   spanning_tree_root_election_table_top u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_dest_bridge  (req_dest_bridge),
      .req_msg_root     (req_msg_root),
      .req_msg_distance (req_msg_distance),
      .req_msg_sender   (req_msg_sender),
      .req_arrival_lan  (req_arrival_lan),
      .rsp_valid        (rsp_valid),
      .rsp_publish      (rsp_publish),
      .rsp_adv_root     (rsp_adv_root),
      .rsp_adv_distance (rsp_adv_distance),
      .rsp_adv_sender   (rsp_adv_sender)
   );

   // Local copy of the bridge table.
   logic [ID_W-1:0]   tbl_root     [MAX_IDS];
   logic [DIST_W-1:0] tbl_distance [MAX_IDS];
   logic [SEND_W-1:0] tbl_sender   [MAX_IDS];
   logic [LAN_W-1:0]  tbl_lan      [MAX_IDS];

   // Predicted advertisements in order; the writer and the reader keep their
   // own counts.
   adv_type pending_adv [ADV_DEPTH];
   int      adv_wr       = 0;
   int      adv_rd       = 0;
   int      mismatches   = 0;
   int      msgs_sent    = 0;
   int      adv_seen     = 0;
   int      publish_seen = 0;
   int      cycle_count  = 0;
   bit      idle_en      = 1'b1;

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("spanning_tree_root_election_table_top: mismatch");
         $finish;
      end
   end

   task automatic clear_table();
      for (int i = 0; i < MAX_IDS; i++) begin
         tbl_root[i]     = ID_W'(i);
         tbl_distance[i] = DIST_NONE;
         tbl_sender[i]   = SENDER_NONE;
         tbl_lan[i]      = '0;
      end
   endtask

   // Applies one message to the local table and returns the advertisement.
   function automatic adv_type elect_root(input logic [ID_W-1:0] dest,
                                          input logic [ID_W-1:0] root,
                                          input logic [ID_W-1:0] hops,
                                          input logic [ID_W-1:0] sender,
                                          input logic [LAN_W-1:0] lan);
      adv_type           adv;
      logic [DIST_W-1:0] new_dist;
      logic              take;
      adv      = '0;
      new_dist = {1'b0, hops} + 8'd1;
      take     = 1'b0;
      if (int'(dest) >= MAX_IDS) return adv;
      if (root < tbl_root[dest]) begin
         take = 1'b1;
      end else if (root == tbl_root[dest] && tbl_distance[dest] != DIST_NONE) begin
         if (new_dist < tbl_distance[dest]) begin
            take = 1'b1;
         end else if (new_dist == tbl_distance[dest] && tbl_sender[dest] != SENDER_NONE
                      && {1'b0, sender} < tbl_sender[dest]) begin
            take = 1'b1;
         end
      end
      if (take) begin
         tbl_root[dest]     = root;
         tbl_distance[dest] = new_dist;
         tbl_sender[dest]   = {1'b0, sender};
         tbl_lan[dest]      = lan;
      end
      adv.publish  = take;
      adv.root     = take ? root : '0;
      adv.distance = new_dist[ID_W-1:0];
      adv.sender   = dest;
      return adv;
   endfunction

   task automatic send_msg(input logic [ID_W-1:0] dest, input logic [ID_W-1:0] root,
                           input logic [ID_W-1:0] hops, input logic [ID_W-1:0] sender,
                           input logic [LAN_W-1:0] lan);
      int gap;
      if (idle_en && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_dest_bridge  <= dest;
      req_msg_root     <= root;
      req_msg_distance <= hops;
      req_msg_sender   <= sender;
      req_arrival_lan  <= lan;
      do @(posedge clock); while (busy !== 1'b0);
      pending_adv[adv_wr % ADV_DEPTH] = elect_root(dest, root, hops, sender, lan);
      adv_wr++;
      msgs_sent++;
   endtask

   always @(posedge clock) begin
      adv_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (adv_wr == adv_rd) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: publish %0b root %0d dist %0d sender %0d",
                        rsp_publish, rsp_adv_root, rsp_adv_distance, rsp_adv_sender);
         end else begin
            want = pending_adv[adv_rd % ADV_DEPTH];
            adv_rd++;
            adv_seen++;
            if (want.publish) publish_seen++;
            if (rsp_publish !== want.publish || rsp_adv_root !== want.root ||
                rsp_adv_distance !== want.distance || rsp_adv_sender !== want.sender) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: want p%0b r%0d d%0d s%0d, got p%0b r%0d d%0d s%0d",
                           adv_seen, want.publish, want.root, want.distance, want.sender,
                           rsp_publish, rsp_adv_root, rsp_adv_distance, rsp_adv_sender);
            end
         end
      end
   end

   // A fresh entry only gives way to a lower root, never to its own root.
   task automatic test_own_root();
      send_msg(7'd5, 7'd5, 7'd0, 7'd0, 8'd0);
      send_msg(7'd0, 7'd0, 7'd0, 7'd0, 8'd0);
      send_msg(7'd5, 7'd127, 7'd126, 7'd127, 8'd255);
   endtask

   task automatic test_lower_root();
      send_msg(7'd5, 7'd0, 7'd3, 7'd9, 8'hA5);
      send_msg(7'd6, 7'd4, 7'd0, 7'd127, 8'h5A);
   endtask

   task automatic test_distance_order();
      send_msg(7'd5, 7'd0, 7'd2, 7'd100, 8'd1);
      send_msg(7'd5, 7'd0, 7'd5, 7'd0, 8'd2);
   endtask

   task automatic test_sender_order();
      send_msg(7'd5, 7'd0, 7'd2, 7'd99, 8'd3);
      send_msg(7'd5, 7'd0, 7'd2, 7'd99, 8'd4);
      send_msg(7'd5, 7'd0, 7'd2, 7'd127, 8'd5);
   endtask

   // A distance of 127 is stored as 128 and advertised as 0.
   task automatic test_distance_wrap();
      send_msg(7'd127, 7'd0, 7'd127, 7'd127, 8'd255);
      send_msg(7'd127, 7'd0, 7'd126, 7'd0, 8'd0);
      send_msg(7'd127, 7'd0, 7'd127, 7'd0, 8'd0);
   endtask

   // Consecutive messages to one bridge exercise the read-after-write path.
   task automatic test_back_to_back();
      idle_en = 1'b0;
      send_msg(7'd10, 7'd3, 7'd10, 7'd5, 8'd7);
      send_msg(7'd10, 7'd2, 7'd10, 7'd5, 8'd7);
      send_msg(7'd10, 7'd2, 7'd9, 7'd5, 8'd7);
      send_msg(7'd10, 7'd2, 7'd9, 7'd4, 8'd7);
      send_msg(7'd10, 7'd2, 7'd9, 7'd4, 8'd7);
      send_msg(7'd10, 7'd1, 7'd0, 7'd0, 8'd0);
      idle_en = 1'b1;
   endtask

   // Half the messages aim near the entry's current best offer so that the distance
   // and sender tie-breaks are reached, some bid a lower root, the rest are plain noise.
   task automatic test_random_traffic(input int count, input bit with_idle);
      int dest, root, hops, sender, mode, jitter;
      idle_en = with_idle;
      for (int n = 0; n < count; n++) begin
         dest   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 15);
         root   = $urandom_range(0, 127);
         hops   = $urandom_range(0, 127);
         sender = $urandom_range(0, 127);
         mode   = $urandom_range(0, 9);
         if (mode <= 4) begin
            root = tbl_root[dest];
            if (tbl_distance[dest] != DIST_NONE) begin
               jitter = $urandom_range(0, 2);
               hops   = int'(tbl_distance[dest]) - 2 + jitter;
               jitter = $urandom_range(0, 3);
               sender = int'(tbl_sender[dest]) - 2 + jitter;
            end
         end else if (mode <= 7) begin
            jitter = $urandom_range(1, 3);
            root   = int'(tbl_root[dest]) - jitter;
            hops   = $urandom_range(0, 8);
         end
         if (root < 0) root = 0;
         if (hops < 0) hops = 0;
         if (hops > 127) hops = 127;
         if (sender < 0) sender = 0;
         if (sender > 127) sender = 127;
         send_msg(ID_W'(dest), ID_W'(root), ID_W'(hops), ID_W'(sender),
                  LAN_W'($urandom_range(0, 255)));
      end
      idle_en = 1'b1;
   endtask

   initial begin
      clear_table();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_own_root();
      test_lower_root();
      test_distance_order();
      test_sender_order();
      test_distance_wrap();
      test_back_to_back();
      test_random_traffic(RANDOM_IDLE, 1'b1);
      test_random_traffic(RANDOM_BURST, 1'b0);
      start <= 1'b0;

      while (adv_wr != adv_rd) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d messages, checked %0d results, %0d of them re-advertised",
               msgs_sent, adv_seen, publish_seen);
      $display("%0d mismatches, %0d results still outstanding",
               mismatches, adv_wr - adv_rd);
      if (mismatches == 0 && adv_wr == adv_rd) begin
         $display("spanning_tree_root_election_table_top: match");
      end else begin
         $display("spanning_tree_root_election_table_top: mismatch");
      end
      $finish;
   end

endmodule
